[src/rvex_pkg.sv]
// Package for the RV32I execute unit: opcodes, function codes, constants
// and the execute-stage result struct. No dependencies.
package rvex_pkg;

   localparam int MEM_ADDR_BITS_DEF = 16;
   localparam int OUT_BITS = 112;

   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BYTE  = 3'd0;
   localparam logic [2:0] F3_HALF  = 3'd1;
   localparam logic [2:0] F3_WORD  = 3'd2;
   localparam logic [2:0] F3_BYTEU = 3'd4;
   localparam logic [2:0] F3_HALFU = 3'd5;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
   localparam logic [31:0] EXIT_CODE  = 32'd10;
   localparam logic [4:0]  ECALL_ARG  = 5'd17;
   localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;
   localparam logic [31:0] HALT_PC    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] npc;
      logic        wr;
      logic [31:0] val;
      logic        st;
      logic        ld;
      logic [2:0]  f3;
      logic        halt;
      logic        bad;
      logic [31:0] addr;
   } ex_type;

endpackage

[src/rv32i_execute_unit.sv]
// RV32I execute unit: register read, execute/memory access, writeback.
// Each instruction passes through the stage-1, stage-2 and output registers;
// throughput one instruction per cycle while rsp_tready does not hold the output,
// set by the single-issue register file and data memory ports. Synchronous reset clears pc, register valid bits and
// pipeline valids; data memory contents stay undefined until stored.
module rv32i_execute_unit #(
   parameter int MEM_ADDR_BITS = rvex_pkg::MEM_ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // instr_address, next_pc, reg_write, dest_reg, write_value, mem_store,
   // halted, illegal, zero pad
   output logic [rvex_pkg::OUT_BITS-1:0] rsp_tdata
);

   localparam int ROW_BITS = MEM_ADDR_BITS - 2;
   localparam int ROWS     = 2 ** ROW_BITS;

   logic req_fire, s1_adv, s2_adv, wb_en;

   // register file
   logic [31:0] rf_mem [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] rf_a_ff, rf_b_ff;
   logic        rf_a_ok_ff, rf_b_ok_ff;
   logic [4:0]  b_addr;
   logic        lw_vld_ff;
   logic [4:0]  lw_addr_ff;
   logic [31:0] lw_data_ff;

   // stage 1
   logic        s1_valid_ff;
   logic [31:0] s1_instr_ff;
   logic [4:0]  s1_b_addr_ff;
   logic [31:0] pc_ff;
   logic [31:0] a_fwd, b_fwd;
   rvex_pkg::ex_type ex;

   // stage 2
   logic        s2_valid_ff;
   logic [31:0] s2_pc_ff, s2_npc_ff, s2_val_ff;
   logic        s2_wr_ff, s2_st_ff, s2_halt_ff, s2_bad_ff, s2_ld_ff;
   logic [4:0]  s2_rd_ff;
   logic [2:0]  s2_f3_ff;
   logic [1:0]  s2_a0_ff;
   logic [31:0] s2_value;
   logic [31:0] ld_word;

   // data memory, four byte lanes
   logic [7:0]          dmem [4][ROWS];
   logic [7:0]          bk_q_ff [4];
   logic [ROW_BITS-1:0] ln_row [4];
   logic                ln_we [4];
   logic [7:0]          ln_byte [4];

   // output register
   logic                          out_valid_ff;
   logic [rvex_pkg::OUT_BITS-1:0] out_data_ff;

   assign s2_adv     = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign wb_en      = s2_adv && s2_wr_ff;
   assign b_addr     = (req_tdata == rvex_pkg::ECALL_WORD) ? rvex_pkg::ECALL_ARG
                                                           : req_tdata[24:20];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rf_a_ff    <= rf_mem[req_tdata[19:15]];
         rf_b_ff    <= rf_mem[b_addr];
         rf_a_ok_ff <= rf_vld_ff[req_tdata[19:15]];
         rf_b_ok_ff <= rf_vld_ff[b_addr];
      end
      if (wb_en) rf_mem[s2_rd_ff] <= s2_value;
   end

   function automatic logic [31:0] fwd(
      input logic [4:0]  ra,
      input logic [31:0] rdat,
      input logic        rok,
      input logic        s2v,
      input logic        s2w,
      input logic [4:0]  s2r,
      input logic [31:0] s2d,
      input logic        lwv,
      input logic [4:0]  lwa,
      input logic [31:0] lwd
   );
      logic [31:0] v;
      if (ra == 5'd0) v = '0;
      else if (s2v && s2w && s2r == ra) v = s2d;
      else if (lwv && lwa == ra) v = lwd;
      else if (rok) v = rdat;
      else v = '0;
      return v;
   endfunction

   assign a_fwd = fwd(s1_instr_ff[19:15], rf_a_ff, rf_a_ok_ff, s2_valid_ff, s2_wr_ff,
                      s2_rd_ff, s2_value, lw_vld_ff, lw_addr_ff, lw_data_ff);
   assign b_fwd = fwd(s1_b_addr_ff, rf_b_ff, rf_b_ok_ff, s2_valid_ff, s2_wr_ff,
                      s2_rd_ff, s2_value, lw_vld_ff, lw_addr_ff, lw_data_ff);

   rvex_alu u_alu (
      .instr (s1_instr_ff),
      .pc    (pc_ff),
      .a     (a_fwd),
      .b     (b_fwd),
      .res   (ex)
   );

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         logic [1:0]  kl;
         logic [31:0] ba;
         kl         = 2'(l) - ex.addr[1:0];
         ba         = ex.addr + {30'b0, kl};
         ln_row[l]  = ba[MEM_ADDR_BITS-1:2];
         ln_byte[l] = b_fwd[8*kl +: 8];
         case (ex.f3)
            rvex_pkg::F3_BYTE: ln_we[l] = ex.st && (kl == 2'd0);
            rvex_pkg::F3_HALF: ln_we[l] = ex.st && (kl <= 2'd1);
            default:           ln_we[l] = ex.st;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         if (s1_adv) begin
            bk_q_ff[l] <= dmem[l][ln_row[l]];
            if (ln_we[l]) dmem[l][ln_row[l]] <= ln_byte[l];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ld_word[8*k +: 8] = bk_q_ff[2'(s2_a0_ff + 2'(k))];
      end
      case (s2_f3_ff)
         rvex_pkg::F3_BYTE:  s2_value = {{24{ld_word[7]}}, ld_word[7:0]};
         rvex_pkg::F3_HALF:  s2_value = {{16{ld_word[15]}}, ld_word[15:0]};
         rvex_pkg::F3_BYTEU: s2_value = {24'b0, ld_word[7:0]};
         rvex_pkg::F3_HALFU: s2_value = {16'b0, ld_word[15:0]};
         default:            s2_value = ld_word;
      endcase
      if (!s2_ld_ff) s2_value = s2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff    <= '0;
         lw_vld_ff    <= 1'b0;
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wb_en) begin
            rf_vld_ff[s2_rd_ff] <= 1'b1;
            lw_vld_ff           <= 1'b1;
         end
         if (s1_adv) pc_ff <= ex.npc;
         if (req_fire) s1_valid_ff <= 1'b1;
         else if (s1_adv) s1_valid_ff <= 1'b0;
         if (s1_adv) s2_valid_ff <= 1'b1;
         else if (s2_adv) s2_valid_ff <= 1'b0;
         if (s2_adv) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         lw_addr_ff <= s2_rd_ff;
         lw_data_ff <= s2_value;
      end
      if (req_fire) begin
         s1_instr_ff  <= req_tdata;
         s1_b_addr_ff <= b_addr;
      end
      if (s1_adv) begin
         s2_pc_ff   <= pc_ff;
         s2_npc_ff  <= ex.npc;
         s2_val_ff  <= ex.val;
         s2_wr_ff   <= ex.wr;
         s2_rd_ff   <= s1_instr_ff[11:7];
         s2_st_ff   <= ex.st;
         s2_halt_ff <= ex.halt;
         s2_bad_ff  <= ex.bad;
         s2_ld_ff   <= ex.ld;
         s2_f3_ff   <= ex.f3;
         s2_a0_ff   <= ex.addr[1:0];
      end
      if (s2_adv) begin
         out_data_ff <= {7'b0, s2_bad_ff, s2_halt_ff, s2_st_ff,
                         s2_wr_ff ? s2_value : 32'b0,
                         s2_wr_ff ? s2_rd_ff : 5'b0,
                         s2_wr_ff, s2_npc_ff, s2_pc_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[src/rvex_alu.sv]
// Decode and execute logic for one RV32I instruction: ALU result, next pc,
// memory address and control flags. Depends on rvex_pkg.
module rvex_alu (
   input  logic [31:0]    instr,
   input  logic [31:0]    pc,
   input  logic [31:0]    a,
   input  logic [31:0]    b,
   output rvex_pkg::ex_type res
);

   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [31:0] immi, imms, immb, immj, immu;
   logic        take;

   assign op = instr[6:0];
   assign rd = instr[11:7];
   assign f3 = instr[14:12];
   assign f7 = instr[31:25];
   assign sh = instr[24:20];
   assign immi = {{20{instr[31]}}, instr[31:20]};
   assign imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign immu = instr & rvex_pkg::UPPER_MASK;

   always_comb begin
      res      = '0;
      res.npc  = pc + 32'd4;
      res.f3   = f3;
      res.addr = a + immi;
      take     = 1'b0;
      case (op)
         rvex_pkg::OP_REG: begin
            res.wr = 1'b1;
            if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_ADD) begin
               res.val = a - b;
            end else if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_SR) begin
               res.val = 32'($signed(a) >>> b[4:0]);
            end else if (f7 != rvex_pkg::F7_BASE) begin
               res.bad = 1'b1;
            end else begin
               case (f3)
                  rvex_pkg::F3_ADD:  res.val = a + b;
                  rvex_pkg::F3_SLL:  res.val = a << b[4:0];
                  rvex_pkg::F3_SLT:  res.val = {31'b0, $signed(a) < $signed(b)};
                  rvex_pkg::F3_SLTU: res.val = {31'b0, a < b};
                  rvex_pkg::F3_XOR:  res.val = a ^ b;
                  rvex_pkg::F3_SR:   res.val = a >> b[4:0];
                  rvex_pkg::F3_OR:   res.val = a | b;
                  default:           res.val = a & b;
               endcase
            end
         end
         rvex_pkg::OP_IMM: begin
            res.wr = 1'b1;
            case (f3)
               rvex_pkg::F3_ADD:  res.val = a + immi;
               rvex_pkg::F3_SLT:  res.val = {31'b0, $signed(a) < $signed(immi)};
               rvex_pkg::F3_SLTU: res.val = {31'b0, a < immi};
               rvex_pkg::F3_XOR:  res.val = a ^ immi;
               rvex_pkg::F3_OR:   res.val = a | immi;
               rvex_pkg::F3_AND:  res.val = a & immi;
               rvex_pkg::F3_SLL: begin
                  if (f7 != rvex_pkg::F7_BASE) res.bad = 1'b1;
                  else res.val = a << sh;
               end
               default: begin
                  if (f7 == rvex_pkg::F7_ALT) res.val = 32'($signed(a) >>> sh);
                  else if (f7 == rvex_pkg::F7_BASE) res.val = a >> sh;
                  else res.bad = 1'b1;
               end
            endcase
         end
         rvex_pkg::OP_LOAD: begin
            res.wr = 1'b1;
            res.ld = 1'b1;
            case (f3)
               rvex_pkg::F3_BYTE, rvex_pkg::F3_HALF, rvex_pkg::F3_WORD,
               rvex_pkg::F3_BYTEU, rvex_pkg::F3_HALFU: res.ld = 1'b1;
               default: res.bad = 1'b1;
            endcase
         end
         rvex_pkg::OP_STORE: begin
            res.addr = a + imms;
            if (f3 > rvex_pkg::F3_WORD) res.bad = 1'b1;
            else res.st = 1'b1;
         end
         rvex_pkg::OP_BRANCH: begin
            case (f3)
               rvex_pkg::F3_BEQ:  take = (a == b);
               rvex_pkg::F3_BNE:  take = (a != b);
               rvex_pkg::F3_BLT:  take = $signed(a) < $signed(b);
               rvex_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
               rvex_pkg::F3_BLTU: take = (a < b);
               rvex_pkg::F3_BGEU: take = (a >= b);
               default:           res.bad = 1'b1;
            endcase
            if (take) res.npc = pc + immb;
         end
         rvex_pkg::OP_LUI: begin
            res.wr  = 1'b1;
            res.val = immu;
         end
         rvex_pkg::OP_AUIPC: begin
            res.wr  = 1'b1;
            res.val = pc + immu;
         end
         rvex_pkg::OP_JAL: begin
            res.wr  = 1'b1;
            res.val = pc + 32'd4;
            res.npc = pc + immj;
         end
         rvex_pkg::OP_JALR: begin
            if (f3 != rvex_pkg::F3_ADD) begin
               res.bad = 1'b1;
            end else begin
               res.wr  = 1'b1;
               res.val = pc + 32'd4;
               res.npc = (a + immi) & ~32'd1;
            end
         end
         rvex_pkg::OP_SYSTEM: begin
            if (instr != rvex_pkg::ECALL_WORD) begin
               res.bad = 1'b1;
            end else if (b == rvex_pkg::EXIT_CODE) begin
               res.halt = 1'b1;
               res.npc  = rvex_pkg::HALT_PC;
            end
         end
         default: res.bad = 1'b1;
      endcase
      if (res.bad) begin
         res.wr  = 1'b0;
         res.st  = 1'b0;
         res.ld  = 1'b0;
         res.npc = pc;
      end
      if (rd == 5'd0) res.wr = 1'b0;
   end

endmodule

[tb/rv32i_execute_unit_tb.sv]
// Testbench for rv32i_execute_unit: directed and random RV32I instruction
// streams checked against a behavioral execute model in a scoreboard class.
// Depends on rvex_pkg and the rv32i_execute_unit RTL.
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;

   localparam int MAB = rvex_pkg::MEM_ADDR_BITS_DEF;
   localparam int MEM_BYTES = 1 << MAB;
   localparam int WATCHDOG = 20000;
   localparam logic [6:0] OP_BAD = 7'h7F;
   localparam logic [2:0] F3_SUB_SEL = rvex_pkg::F3_ADD;

   typedef struct packed {
      logic        illegal;
      logic        halted;
      logic        mem_store;
      logic [31:0] write_value;
      logic [4:0]  dest_reg;
      logic        reg_write;
      logic [31:0] next_pc;
      logic [31:0] instr_address;
   } retire_type;

   class retire_board;
      logic [31:0] pc;
      logic [31:0] regs [32];
      logic [7:0]  mem [MEM_BYTES];
      retire_type  pending [$];
      int          errors;
      int          retired;

      function new();
         pc = '0;
         foreach (regs[i]) regs[i] = '0;
         errors = 0;
         retired = 0;
      endfunction

      function logic [31:0] rd8(logic [31:0] a);
         return {24'd0, mem[a[MAB-1:0]]};
      endfunction

      function void note_instr(logic [31:0] w);
         retire_type r;
         logic [6:0] op, f7;
         logic [4:0] rd, r1, r2;
         logic [2:0] f3;
         logic [31:0] a, b, immi, imms, immb, immj, npc, val, ad;
         logic wr, st, halt, bad, take;
         op = w[6:0]; rd = w[11:7]; f3 = w[14:12];
         r1 = w[19:15]; r2 = w[24:20]; f7 = w[31:25];
         a = regs[r1]; b = regs[r2];
         immi = {{20{w[31]}}, w[31:20]};
         imms = {{20{w[31]}}, w[31:25], w[11:7]};
         immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         npc = pc + 4; val = '0; wr = 0; st = 0; halt = 0; bad = 0; take = 0;
         case (op)
            rvex_pkg::OP_REG: begin
               wr = 1;
               if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_ADD) val = a - b;
               else if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_SR)
                  val = $signed(a) >>> b[4:0];
               else if (f7 != rvex_pkg::F7_BASE) bad = 1;
               else case (f3)
                  rvex_pkg::F3_ADD:  val = a + b;
                  rvex_pkg::F3_SLL:  val = a << b[4:0];
                  rvex_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                  rvex_pkg::F3_SLTU: val = {31'd0, a < b};
                  rvex_pkg::F3_XOR:  val = a ^ b;
                  rvex_pkg::F3_SR:   val = a >> b[4:0];
                  rvex_pkg::F3_OR:   val = a | b;
                  default:           val = a & b;
               endcase
            end
            rvex_pkg::OP_IMM: begin
               wr = 1;
               case (f3)
                  rvex_pkg::F3_ADD:  val = a + immi;
                  rvex_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(immi)};
                  rvex_pkg::F3_SLTU: val = {31'd0, a < immi};
                  rvex_pkg::F3_XOR:  val = a ^ immi;
                  rvex_pkg::F3_OR:   val = a | immi;
                  rvex_pkg::F3_AND:  val = a & immi;
                  rvex_pkg::F3_SLL:  if (f7 != rvex_pkg::F7_BASE) bad = 1; else val = a << r2;
                  default: begin
                     if (f7 == rvex_pkg::F7_ALT) val = $signed(a) >>> r2;
                     else if (f7 == rvex_pkg::F7_BASE) val = a >> r2;
                     else bad = 1;
                  end
               endcase
            end
            rvex_pkg::OP_LOAD: begin
               wr = 1; ad = a + immi;
               case (f3)
                  rvex_pkg::F3_BYTE:  val = {{24{mem[ad[MAB-1:0]][7]}}, mem[ad[MAB-1:0]]};
                  rvex_pkg::F3_HALF:  begin
                     val = rd8(ad) | (rd8(ad + 1) << 8);
                     val = {{16{val[15]}}, val[15:0]};
                  end
                  rvex_pkg::F3_WORD:  val = rd8(ad) | (rd8(ad + 1) << 8) | (rd8(ad + 2) << 16)
                                            | (rd8(ad + 3) << 24);
                  rvex_pkg::F3_BYTEU: val = rd8(ad);
                  rvex_pkg::F3_HALFU: val = rd8(ad) | (rd8(ad + 1) << 8);
                  default:            bad = 1;
               endcase
            end
            rvex_pkg::OP_STORE: begin
               ad = a + imms;
               if (f3 > rvex_pkg::F3_WORD) bad = 1;
               else begin
                  for (int k = 0; k < (1 << f3); k++) begin
                     logic [31:0] ak;
                     ak = ad + k;
                     mem[ak[MAB-1:0]] = b[8*k +: 8];
                  end
                  st = 1;
               end
            end
            rvex_pkg::OP_BRANCH: begin
               case (f3)
                  rvex_pkg::F3_BEQ:  take = a == b;
                  rvex_pkg::F3_BNE:  take = a != b;
                  rvex_pkg::F3_BLT:  take = $signed(a) < $signed(b);
                  rvex_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
                  rvex_pkg::F3_BLTU: take = a < b;
                  rvex_pkg::F3_BGEU: take = a >= b;
                  default:           bad = 1;
               endcase
               if (take) npc = pc + immb;
            end
            rvex_pkg::OP_LUI:   begin wr = 1; val = w & rvex_pkg::UPPER_MASK; end
            rvex_pkg::OP_AUIPC: begin wr = 1; val = pc + (w & rvex_pkg::UPPER_MASK); end
            rvex_pkg::OP_JAL:   begin wr = 1; val = pc + 4; npc = pc + immj; end
            rvex_pkg::OP_JALR: begin
               if (f3 != 3'd0) bad = 1;
               else begin
                  wr = 1; val = pc + 4; npc = (a + immi) & ~32'd1;
               end
            end
            rvex_pkg::OP_SYSTEM: begin
               if (w != rvex_pkg::ECALL_WORD) bad = 1;
               else if (regs[rvex_pkg::ECALL_ARG] == rvex_pkg::EXIT_CODE) begin
                  halt = 1; npc = rvex_pkg::HALT_PC;
               end
            end
            default: bad = 1;
         endcase
         if (bad) begin wr = 0; st = 0; npc = pc; end
         if (rd == 0) wr = 0;
         if (wr) regs[rd] = val;
         r.instr_address = pc;
         r.next_pc = npc;
         r.reg_write = wr;
         r.dest_reg = wr ? rd : 5'd0;
         r.write_value = wr ? val : 32'd0;
         r.mem_store = st;
         r.halted = halt;
         r.illegal = bad;
         pc = npc;
         pending.push_back(r);
      endfunction

      function void check_retire(retire_type got);
         retire_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         retired++;
         if (got.instr_address !== e.instr_address) begin
            $error("instr_address exp %h got %h", e.instr_address, got.instr_address);
            errors++;
         end
         if (got.next_pc !== e.next_pc) begin
            $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
         end
         if (got.reg_write !== e.reg_write) begin
            $error("reg_write exp %h got %h", e.reg_write, got.reg_write); errors++;
         end
         if (got.dest_reg !== e.dest_reg) begin
            $error("dest_reg exp %h got %h", e.dest_reg, got.dest_reg); errors++;
         end
         if (got.write_value !== e.write_value) begin
            $error("write_value exp %h got %h", e.write_value, got.write_value);
            errors++;
         end
         if (got.mem_store !== e.mem_store) begin
            $error("mem_store exp %h got %h", e.mem_store, got.mem_store); errors++;
         end
         if (got.halted !== e.halted) begin
            $error("halted exp %h got %h", e.halted, got.halted); errors++;
         end
         if (got.illegal !== e.illegal) begin
            $error("illegal exp %h got %h", e.illegal, got.illegal); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [rvex_pkg::OUT_BITS-1:0] rsp_tdata;

   retire_board board;
   int send_idle_pct, recv_idle_pct;
   bit hold_rsp;
   int idle_cycles;
   int sent;
   logic [MEM_BYTES-1:0] written;

   rv32i_execute_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_retire(retire_type'(rsp_tdata[$bits(retire_type)-1:0]));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] r2, logic [4:0] r1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, r2, r1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] r1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, r1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] r2, logic [4:0] r1,
                                         logic [2:0] f3);
      return {imm[11:5], r2, r1, f3, imm[4:0], rvex_pkg::OP_STORE};
   endfunction

   // x1 holds the memory base (0); keep it out of random destinations
   function automatic logic [4:0] rand_rd();
      logic [4:0] r;
      r = 5'($urandom);
      if (r == 5'd1) r = 5'd0;
      return r;
   endfunction

   // loads only hit bytes already stored: base x1 = 0, offsets from stored set
   function automatic logic [31:0] pick_load();
      logic [2:0] f3s [5] = '{rvex_pkg::F3_BYTE, rvex_pkg::F3_HALF, rvex_pkg::F3_WORD,
                              rvex_pkg::F3_BYTEU, rvex_pkg::F3_HALFU};
      logic [2:0] f3;
      int n;
      logic [11:0] off;
      f3 = f3s[$urandom_range(4)];
      n = (f3 == rvex_pkg::F3_WORD) ? 4
        : (f3 == rvex_pkg::F3_HALF || f3 == rvex_pkg::F3_HALFU) ? 2 : 1;
      for (int t = 0; t < 50; t++) begin
         bit ok;
         off = 12'($urandom_range(63)) | ($urandom_range(1) ? 12'hFC0 : 12'h000);
         ok = 1;
         for (int k = 0; k < n; k++) begin
            logic [31:0] ak;
            ak = {{20{off[11]}}, off} + k;
            if (!written[ak[MAB-1:0]]) ok = 0;
         end
         if (ok) return enc_i(off, 5'd1, f3, rand_rd(), rvex_pkg::OP_LOAD);
      end
      return enc_i(12'h000, 5'd1, rvex_pkg::F3_BYTE, 5'd0, rvex_pkg::OP_LUI);
   endfunction

   function automatic logic [31:0] pick_store();
      logic [2:0] f3;
      logic [11:0] off;
      f3 = 3'($urandom_range(2));
      off = 12'($urandom_range(63)) | ($urandom_range(1) ? 12'hFC0 : 12'h000);
      for (int k = 0; k < (1 << f3); k++) begin
         logic [31:0] ak;
         ak = {{20{off[11]}}, off} + k;
         written[ak[MAB-1:0]] = 1'b1;
      end
      return enc_s(off, 5'($urandom), 5'd1, f3);
   endfunction

   function automatic logic [31:0] pick_random();
      logic [31:0] w;
      int sel;
      w = $urandom;
      sel = $urandom_range(99);
      if (sel < 25) begin
         w[6:0] = rvex_pkg::OP_REG;
         w[31:25] = $urandom_range(3) == 0 ? rvex_pkg::F7_ALT
                  : ($urandom_range(9) == 0 ? w[31:25] : rvex_pkg::F7_BASE);
      end else if (sel < 45) begin
         w[6:0] = rvex_pkg::OP_IMM;
         if (w[14:12] == rvex_pkg::F3_SLL || w[14:12] == rvex_pkg::F3_SR)
            w[31:25] = $urandom_range(9) == 0 ? w[31:25]
                     : ($urandom_range(1) ? rvex_pkg::F7_ALT : rvex_pkg::F7_BASE);
      end else if (sel < 55) return pick_store();
      else if (sel < 63) return pick_load();
      else if (sel < 73) w[6:0] = rvex_pkg::OP_BRANCH;
      else if (sel < 77) w[6:0] = rvex_pkg::OP_LUI;
      else if (sel < 81) w[6:0] = rvex_pkg::OP_AUIPC;
      else if (sel < 85) w[6:0] = rvex_pkg::OP_JAL;
      else if (sel < 89) begin
         w[6:0] = rvex_pkg::OP_JALR;
         if ($urandom_range(4) != 0) w[14:12] = 3'd0;
      end else if (sel < 93) w = $urandom_range(3) == 0 ? w : rvex_pkg::ECALL_WORD;
      else if (sel < 96) w[6:0] = rvex_pkg::OP_SYSTEM;
      if (w[6:0] != rvex_pkg::OP_STORE && w[6:0] != rvex_pkg::OP_BRANCH
          && w[6:0] != rvex_pkg::OP_SYSTEM && w[11:7] == 5'd1)
         w[11:7] = 5'd0;
      if (w[6:0] == rvex_pkg::OP_STORE || w[6:0] == rvex_pkg::OP_LOAD) w[6:0] = OP_BAD;
      return w;
   endfunction

   task automatic send_instr(logic [31:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_instr(w);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed [$];
      board = new();
      written = '0;
      sent = 0;
      hold_rsp = 0;
      send_idle_pct = 37;
      recv_idle_pct = 45;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed = '{
         enc_i(12'hFFF, 5'd0, rvex_pkg::F3_ADD, 5'd2, rvex_pkg::OP_IMM),
         enc_i(12'h7FF, 5'd0, rvex_pkg::F3_ADD, 5'd3, rvex_pkg::OP_IMM),
         32'h8000_0237,
         enc_r(rvex_pkg::F7_BASE, 5'd2, 5'd3, rvex_pkg::F3_ADD, 5'd5, rvex_pkg::OP_REG),
         enc_r(rvex_pkg::F7_ALT, 5'd2, 5'd4, F3_SUB_SEL, 5'd6, rvex_pkg::OP_REG),
         enc_r(rvex_pkg::F7_ALT, 5'd2, 5'd4, rvex_pkg::F3_SR, 5'd7, rvex_pkg::OP_REG),
         enc_r(rvex_pkg::F7_BASE, 5'd3, 5'd2, rvex_pkg::F3_SLT, 5'd8, rvex_pkg::OP_REG),
         enc_r(rvex_pkg::F7_BASE, 5'd3, 5'd2, rvex_pkg::F3_SLTU, 5'd9, rvex_pkg::OP_REG),
         enc_i({rvex_pkg::F7_ALT, 5'd31}, 5'd4, rvex_pkg::F3_SR, 5'd10, rvex_pkg::OP_IMM),
         enc_i({rvex_pkg::F7_BASE, 5'd31}, 5'd2, rvex_pkg::F3_SLL, 5'd11, rvex_pkg::OP_IMM),
         enc_i({7'h01, 5'd1}, 5'd2, rvex_pkg::F3_SLL, 5'd12, rvex_pkg::OP_IMM),
         enc_s(12'hFFF, 5'd4, 5'd0, rvex_pkg::F3_WORD),
         enc_s(12'h000, 5'd2, 5'd0, rvex_pkg::F3_HALF),
         enc_s(12'h7FF, 5'd3, 5'd0, rvex_pkg::F3_BYTE),
         enc_i(12'hFFF, 5'd0, rvex_pkg::F3_WORD, 5'd13, rvex_pkg::OP_LOAD),
         enc_i(12'h000, 5'd0, rvex_pkg::F3_HALF, 5'd14, rvex_pkg::OP_LOAD),
         enc_i(12'h7FF, 5'd0, rvex_pkg::F3_BYTEU, 5'd15, rvex_pkg::OP_LOAD),
         enc_i(12'hFFF, 5'd0, rvex_pkg::F3_WORD, 5'd0, rvex_pkg::OP_LOAD),
         enc_s(12'h000, 5'd2, 5'd0, 3'd3),
         {1'b1, 6'h3F, 5'd2, 5'd2, rvex_pkg::F3_BEQ, 4'hF, 1'b1, rvex_pkg::OP_BRANCH},
         {7'h00, 5'd3, 5'd2, 3'd2, 5'd8, rvex_pkg::OP_BRANCH},
         32'h0000_0067 | (5'd16 << 7) | (5'd3 << 15) | (12'h001 << 20),
         32'h8000_006F | (5'd18 << 7),
         32'h0010_0073,
         enc_i(12'd10, 5'd0, rvex_pkg::F3_ADD, 5'd17, rvex_pkg::OP_IMM)
      };
      foreach (directed[i]) send_instr(directed[i]);
      send_instr(rvex_pkg::ECALL_WORD);
      send_instr(32'hFFFF_FFFF);
      drain();
      for (int k = 0; k < 3; k++) written[k] = 1'b1;
      written[16'h07FF] = 1'b1;
      written[MEM_BYTES-1] = 1'b1;
      send_instr(enc_i(12'h000, 5'd0, rvex_pkg::F3_ADD, 5'd17, rvex_pkg::OP_IMM));

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 45 : 0;
         recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 37 : 0;
         if (ph == 2) begin
            hold_rsp = 1;
            fork
               begin
                  repeat (60) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int n = 0; n < 170; n++) send_instr(pick_random());
         drain();
      end

      $display("Covered %0d instructions, %0d results checked, across ALU, memory,",
               sent, board.retired);
      $display("branch, jump, ecall and illegal encodings under three idle mixes.");
      if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
src/rvex_pkg.sv
src/rvex_alu.sv
src/rv32i_execute_unit.sv
tb/rv32i_execute_unit_tb.sv
